FILE: hdl/ffa_pkg.sv
package ffa_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int HDR_W      = 7;
	localparam int OUT_ADDR_W = 32;

	localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 32'd65536;
	localparam logic [HDR_W-1:0]      HDR_RESET   = 7'd16;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEAP_BASE    = 2'd0,
		CFG_HEAP_LIMIT   = 2'd1,
		CFG_HEADER_BYTES = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_REUSED   = 3'd0,
		ST_NEW      = 3'd1,
		ST_RELEASED = 3'd2,
		ST_NOTHING  = 3'd3,
		ST_NO_HEAP  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

endpackage

FILE: hdl/ffa_ifs.sv
interface ffa_req_if #(
	parameter int SIZE_BITS = 16,
	parameter int HANDLE_W  = 7
);
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [SIZE_BITS-1:0] request_size;
	logic [HANDLE_W-1:0]  handle;

	modport source (output valid, output mode, output request_size, output handle, input ready);
	modport sink   (input valid, input mode, input request_size, input handle, output ready);
	modport mon    (input valid, input mode, input request_size, input handle, input ready);
endinterface

interface ffa_rsp_if #(
	parameter int HANDLE_W = 7
);
	logic                                valid;
	logic                                ready;
	logic [2:0]                          status;
	logic [ffa_pkg::OUT_ADDR_W-1:0]      address;
	logic [HANDLE_W-1:0]                 chunk_handle;

	modport source (output valid, output status, output address, output chunk_handle, input ready);
	modport sink   (input valid, input status, input address, input chunk_handle, output ready);
	modport mon    (input valid, input status, input address, input chunk_handle, input ready);
endinterface

FILE: hdl/first_fit_free_list_allocator.sv
// First-fit chunk allocator. Each request transaction on req gives exactly one result
// transaction on rsp, and one request is worked on at a time. The chunk table (start,
// size and an on-free-list flag per handle) and the free list (slot numbers, most
// recently released on top) sit in two RAMs with registered reads. A release reads the
// chunk table in S_REL_RD, checks and marks it in S_REL_CHK and reaches the result
// register through S_FIN; a zero-size request or a null or unknown handle goes straight
// to S_FIN. An allocate walks the free list from its top, one entry per cycle through a
// two-deep read pipeline (free list, then chunk table): on a fit the entries above the
// hit are then moved down one per cycle through the free-list RAM port, and a walk of
// all entries without a fit goes to S_CHECK, which makes a new chunk unless the heap or
// the table is exhausted. The result register frees the request side while a result
// waits to be taken.
module first_fit_free_list_allocator #(
	parameter int MAX_CHUNKS = 64,
	parameter int SIZE_BITS  = 16,
	parameter int ADDR_BITS  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ffa_req_if.sink                         req,
	ffa_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDXW = $clog2(MAX_CHUNKS);
	localparam int CNTW = $clog2(MAX_CHUNKS + 1);
	localparam int CW   = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;

	typedef struct packed {
		logic                 free;
		logic [ADDR_BITS-1:0] start;
		logic [SIZE_BITS-1:0] bytes;
	} chunk_t;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_SCAN    = 9'b000000010,
		S_REUSE   = 9'b000000100,
		S_SHIFT   = 9'b000001000,
		S_CHECK   = 9'b000010000,
		S_NEW     = 9'b000100000,
		S_REL_RD  = 9'b001000000,
		S_REL_CHK = 9'b010000000,
		S_FIN     = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [ffa_pkg::CFG_DATA_W-1:0] base_q;
	logic [ffa_pkg::CFG_DATA_W-1:0] limit_q;
	logic [ffa_pkg::HDR_W-1:0]      hdr_q;

	logic [ADDR_BITS-1:0] break_q;
	logic [CNTW-1:0]      chunk_cnt_q;
	logic [CNTW-1:0]      free_cnt_q;

	logic [SIZE_BITS-1:0] size_q;
	logic [IDXW-1:0]      slot_q;
	logic [ADDR_BITS-1:0] start_q;
	logic [SIZE_BITS-1:0] hit_bytes_q;
	logic                 shift_q;

	logic                 issue_q;
	logic [IDXW-1:0]      scan_idx_q;
	logic                 v_s1, v_s2;
	logic [IDXW-1:0]      idx_s1, idx_s2;
	logic [IDXW-1:0]      slot_s2;

	logic                 sh_issue_q;
	logic [IDXW-1:0]      rd_q;
	logic                 sh_v_s1;
	logic [IDXW-1:0]      wr_idx_s1;

	ffa_pkg::status_t     res_status_q;
	logic [ffa_pkg::OUT_ADDR_W-1:0] res_addr_q;
	logic [CNTW-1:0]      res_handle_q;

	logic                 rsp_valid_q;
	ffa_pkg::status_t     rsp_status_q;
	logic [ffa_pkg::OUT_ADDR_W-1:0] rsp_addr_q;
	logic [CNTW-1:0]      rsp_handle_q;

	logic                 fo_we;
	logic [IDXW-1:0]      fo_waddr, fo_wdata, fo_raddr, fo_rdata;
	logic                 ct_we;
	logic [IDXW-1:0]      ct_waddr, ct_raddr;
	chunk_t               ct_wdata, ct_rd;

	logic                 acc, rel_bad, fits, hit, scan_miss_end, sh_last;
	logic                 over, full, rel_ok, fin_load;
	logic [CNTW-1:0]      fc_m1, rel_slot_w;
	logic [CW-1:0]        need_end;
	logic [ADDR_BITS-1:0] addr_start, addr_sum;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && (state_q == S_IDLE);
	assign rel_bad   = (req.handle == '0) || (req.handle > chunk_cnt_q);
	assign rel_slot_w = req.handle - CNTW'(1);
	assign fc_m1     = free_cnt_q - CNTW'(1);

	assign fits          = (ct_rd.bytes >= size_q);
	assign hit           = (state_q == S_SCAN) && v_s2 && fits;
	assign scan_miss_end = (state_q == S_SCAN) && v_s2 && !fits && (idx_s2 == '0);
	assign sh_last       = sh_v_s1 && !sh_issue_q;

	// The break limit check is done on a width that cannot overflow.
	assign need_end = CW'(break_q) + CW'(size_q) + CW'(hdr_q);
	assign over     = need_end > CW'(limit_q);
	assign full     = (chunk_cnt_q == CNTW'(MAX_CHUNKS));
	assign rel_ok   = !ct_rd.free && (free_cnt_q != CNTW'(MAX_CHUNKS));
	assign fin_load = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	assign addr_start = (state_q == S_NEW) ? break_q : start_q;
	assign addr_sum   = ADDR_BITS'(base_q) + addr_start + ADDR_BITS'(hdr_q);

	assign fo_raddr = (state_q == S_SHIFT) ? rd_q : scan_idx_q;
	assign ct_raddr = (state_q == S_SCAN) ? fo_rdata : slot_q;

	always_comb begin
		fo_we    = 1'b0;
		fo_waddr = free_cnt_q[IDXW-1:0];
		fo_wdata = slot_q;
		ct_we    = 1'b0;
		ct_waddr = slot_q;
		ct_wdata = '{free: 1'b0, start: start_q, bytes: hit_bytes_q};
		if (state_q == S_SHIFT) begin
			fo_we    = sh_v_s1;
			fo_waddr = wr_idx_s1;
			fo_wdata = fo_rdata;
		end
		if (state_q == S_REUSE) begin
			ct_we = 1'b1;
		end
		if (state_q == S_NEW) begin
			ct_we    = 1'b1;
			ct_waddr = chunk_cnt_q[IDXW-1:0];
			ct_wdata = '{free: 1'b0, start: break_q, bytes: size_q};
		end
		if ((state_q == S_REL_CHK) && rel_ok) begin
			fo_we    = 1'b1;
			ct_we    = 1'b1;
			ct_wdata = '{free: 1'b1, start: ct_rd.start, bytes: ct_rd.bytes};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (req.mode == ffa_pkg::MODE_RELEASE) begin
						state_d = rel_bad ? S_FIN : S_REL_RD;
					end else if (req.request_size == '0) begin
						state_d = S_FIN;
					end else if (free_cnt_q == '0) begin
						state_d = S_CHECK;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_REUSE;
				end else if (scan_miss_end) begin
					state_d = S_CHECK;
				end
			end
			S_REUSE:   state_d = shift_q ? S_SHIFT : S_FIN;
			S_SHIFT:   state_d = sh_last ? S_FIN : S_SHIFT;
			S_CHECK:   state_d = (over || full) ? S_FIN : S_NEW;
			S_NEW:     state_d = S_FIN;
			S_REL_RD:  state_d = S_REL_CHK;
			S_REL_CHK: state_d = S_FIN;
			S_FIN:     state_d = fin_load ? S_IDLE : S_FIN;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			limit_q     <= ffa_pkg::LIMIT_RESET;
			hdr_q       <= ffa_pkg::HDR_RESET;
			break_q     <= '0;
			chunk_cnt_q <= '0;
			free_cnt_q  <= '0;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			sh_issue_q  <= 1'b0;
			sh_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					ffa_pkg::CFG_HEAP_BASE:    base_q  <= cfg_data;
					ffa_pkg::CFG_HEAP_LIMIT:   limit_q <= cfg_data;
					ffa_pkg::CFG_HEADER_BYTES: hdr_q   <= cfg_data[ffa_pkg::HDR_W-1:0];
					default: ;
				endcase
			end
			if (acc) begin
				issue_q <= 1'b1;
				v_s1    <= 1'b0;
				v_s2    <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				v_s1 <= issue_q;
				v_s2 <= v_s1;
				if (issue_q && (scan_idx_q == '0)) begin
					issue_q <= 1'b0;
				end
			end
			if (state_q == S_REUSE) begin
				free_cnt_q <= fc_m1;
				sh_issue_q <= 1'b1;
				sh_v_s1    <= 1'b0;
			end
			if (state_q == S_SHIFT) begin
				sh_v_s1 <= sh_issue_q;
				if (sh_issue_q && (CNTW'(rd_q) == free_cnt_q)) begin
					sh_issue_q <= 1'b0;
				end
			end
			if (state_q == S_NEW) begin
				break_q     <= break_q + ADDR_BITS'(size_q) + ADDR_BITS'(hdr_q);
				chunk_cnt_q <= chunk_cnt_q + CNTW'(1);
			end
			if ((state_q == S_REL_CHK) && rel_ok) begin
				free_cnt_q <= free_cnt_q + CNTW'(1);
			end
			if (fin_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			size_q       <= req.request_size;
			slot_q       <= rel_slot_w[IDXW-1:0];
			scan_idx_q   <= fc_m1[IDXW-1:0];
			res_status_q <= ffa_pkg::ST_NOTHING;
			res_addr_q   <= '0;
			res_handle_q <= '0;
		end
		if (state_q == S_SCAN) begin
			if (issue_q) begin
				idx_s1 <= scan_idx_q;
				if (scan_idx_q != '0) begin
					scan_idx_q <= scan_idx_q - IDXW'(1);
				end
			end
			idx_s2  <= idx_s1;
			slot_s2 <= fo_rdata;
		end
		if (hit) begin
			slot_q      <= slot_s2;
			start_q     <= ct_rd.start;
			hit_bytes_q <= ct_rd.bytes;
			rd_q        <= idx_s2 + IDXW'(1);
			// Entries above the hit slide down one place to close the gap.
			shift_q     <= (CNTW'(idx_s2) != fc_m1);
		end
		if ((state_q == S_SHIFT) && sh_issue_q) begin
			wr_idx_s1 <= rd_q - IDXW'(1);
			rd_q      <= rd_q + IDXW'(1);
		end
		if (state_q == S_REUSE) begin
			res_status_q <= ffa_pkg::ST_REUSED;
			res_addr_q   <= ffa_pkg::OUT_ADDR_W'(addr_sum);
			res_handle_q <= CNTW'(slot_q) + CNTW'(1);
		end
		if (state_q == S_NEW) begin
			res_status_q <= ffa_pkg::ST_NEW;
			res_addr_q   <= ffa_pkg::OUT_ADDR_W'(addr_sum);
			res_handle_q <= chunk_cnt_q + CNTW'(1);
		end
		if (state_q == S_CHECK) begin
			if (over) begin
				res_status_q <= ffa_pkg::ST_NO_HEAP;
			end else if (full) begin
				res_status_q <= ffa_pkg::ST_FULL;
			end
		end
		if ((state_q == S_REL_CHK) && rel_ok) begin
			res_status_q <= ffa_pkg::ST_RELEASED;
		end
		if (fin_load) begin
			rsp_status_q <= res_status_q;
			rsp_addr_q   <= res_addr_q;
			rsp_handle_q <= res_handle_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.address      = rsp_addr_q;
	assign rsp.chunk_handle = rsp_handle_q;

	ffa_ram #(
		.WIDTH(IDXW),
		.DEPTH(MAX_CHUNKS)
	) u_free_ram (
		.clk  (clk),
		.we   (fo_we),
		.waddr(fo_waddr),
		.wdata(fo_wdata),
		.raddr(fo_raddr),
		.rdata(fo_rdata)
	);

	ffa_ram #(
		.WIDTH($bits(chunk_t)),
		.DEPTH(MAX_CHUNKS)
	) u_chunk_ram (
		.clk  (clk),
		.we   (ct_we),
		.waddr(ct_waddr),
		.wdata(ct_wdata),
		.raddr(ct_raddr),
		.rdata(ct_rd)
	);

endmodule

FILE: hdl/ffa_ram.sv
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/ffa_checker.sv
module ffa_checker #(
	parameter int HANDLE_W = 7
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [2:0]                     rsp_status,
	input logic [ffa_pkg::OUT_ADDR_W-1:0] rsp_address,
	input logic [HANDLE_W-1:0]            rsp_chunk_handle
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Result withdrawn before its transaction completed.");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_address)
			&& $stable(rsp_chunk_handle))
		else $error("Result payload changed while stalled.");

	// A result is loaded only while the request side is closed for the item in flight.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("Result appeared while requests were being taken.");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ffa_pkg::ST_RELEASED || rsp_status == ffa_pkg::ST_NOTHING
			|| rsp_status == ffa_pkg::ST_NO_HEAP || rsp_status == ffa_pkg::ST_FULL)
		|-> rsp_address == '0 && rsp_chunk_handle == '0)
		else $error("Address or handle given without a chunk.");

	a_handle_given: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ffa_pkg::ST_REUSED || rsp_status == ffa_pkg::ST_NEW)
		|-> rsp_chunk_handle != '0)
		else $error("Chunk handed out with the null handle.");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_address     (rsp.address),
	.rsp_chunk_handle(rsp.chunk_handle)
);
